[src/fdi_pkg.sv]
// Shared constants, codes and saturation helpers for the forward difference interpolator.
package fdi_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Q16.16 working values carry 48 bits and are held within +-(2^47 - 1).
    localparam int QW    = 48;
    localparam int DVD_W = 49;
    localparam int DSR_W = 31;

    localparam logic signed [QW-1:0] QLIM = 48'sh7FFF_FFFF_FFFF;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_EVAL  = 2'd2;

    localparam logic [1:0] REG_X_ORIGIN    = 2'd0;
    localparam logic [1:0] REG_STEP_SIZE   = 2'd1;
    localparam logic [1:0] REG_POINT_COUNT = 2'd2;

    function automatic logic ovf_q(input logic signed [QW:0] v);
        logic signed [QW:0] lim;
        lim = {QLIM[QW-1], QLIM};
        return (v > lim) || (v < -lim);
    endfunction

    function automatic logic signed [QW-1:0] clamp_q(input logic signed [QW:0] v);
        logic signed [QW:0] lim;
        lim = {QLIM[QW-1], QLIM};
        if (v > lim) begin
            return QLIM;
        end else if (v < -lim) begin
            return -QLIM;
        end
        return v[QW-1:0];
    endfunction

endpackage

[src/fdi_div.sv]
// Iterative restoring divider on unsigned magnitudes, one quotient bit per cycle.
module fdi_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [fdi_pkg::DVD_W-1:0]        dividend,
    input  logic [fdi_pkg::DSR_W-1:0]        divisor,
    output logic                             done,
    output logic [fdi_pkg::DVD_W-1:0]        quotient
);

    localparam int STEP_W = $clog2(fdi_pkg::DVD_W + 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [STEP_W-1:0]             cnt_reg, cnt_next;
    logic [fdi_pkg::DVD_W-1:0]     q_reg, q_next;
    logic [fdi_pkg::DSR_W-1:0]     rem_reg, rem_next;
    logic [fdi_pkg::DSR_W-1:0]     dsr_reg, dsr_next;
    logic [fdi_pkg::DSR_W:0]       trial;

    assign trial = {rem_reg, q_reg[fdi_pkg::DVD_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = trial[fdi_pkg::DSR_W-1:0] - dsr_reg;
                q_next   = {q_reg[fdi_pkg::DVD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[fdi_pkg::DSR_W-1:0];
                q_next   = {q_reg[fdi_pkg::DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(fdi_pkg::DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[src/fdi_qmul.sv]
// Sequenced Q16.16 multiply built from three partial products on one 32 by 32 multiplier.
module fdi_qmul (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic signed [fdi_pkg::QW-1:0]  op_a,
    input  logic signed [fdi_pkg::QW-1:0]  op_b,
    output logic                           done,
    output logic signed [fdi_pkg::QW-1:0]  result,
    output logic                           sat
);

    localparam logic [2:0] Q_IDLE = 3'd0;
    localparam logic [2:0] Q_M0   = 3'd1;
    localparam logic [2:0] Q_M1   = 3'd2;
    localparam logic [2:0] Q_M2   = 3'd3;
    localparam logic [2:0] Q_FIN  = 3'd4;

    localparam int HI_W = fdi_pkg::QW - 1 - 32;

    logic [2:0]                   state_reg, state_next;
    logic [fdi_pkg::QW-2:0]       ma_reg, ma_next, mb_reg, mb_next;
    logic                         neg_reg, neg_next;
    logic [63:0]                  p00_reg, p00_next;
    logic [fdi_pkg::QW-1:0]       mid_reg, mid_next;
    logic                         done_reg, done_next;
    logic signed [fdi_pkg::QW-1:0] res_reg, res_next;
    logic                         sat_reg, sat_next;

    logic [31:0]                  mul_a, mul_b;
    logic [63:0]                  prod;
    logic [HI_W-1:0]              a1, b1;
    logic [fdi_pkg::QW:0]         r;
    logic                         over;
    logic signed [fdi_pkg::QW-1:0] abs_a, abs_b;

    assign a1 = ma_reg[fdi_pkg::QW-2:32];
    assign b1 = mb_reg[fdi_pkg::QW-2:32];
    assign prod = mul_a * mul_b;
    assign abs_a = op_a[fdi_pkg::QW-1] ? -op_a : op_a;
    assign abs_b = op_b[fdi_pkg::QW-1] ? -op_b : op_b;

    always_comb begin
        case (state_reg)
            Q_M1: begin
                mul_a = {{(32-HI_W){1'b0}}, a1};
                mul_b = mb_reg[31:0];
            end
            Q_M2: begin
                mul_a = ma_reg[31:0];
                mul_b = {{(32-HI_W){1'b0}}, b1};
            end
            default: begin
                mul_a = ma_reg[31:0];
                mul_b = mb_reg[31:0];
            end
        endcase
    end

    assign r = {2'b0, mid_reg[30:0], 16'b0} + {{(fdi_pkg::QW-47){1'b0}}, p00_reg[63:16]};
    assign over = ((a1 != '0) && (b1 != '0)) || (mid_reg >= fdi_pkg::QW'(64'h8000_0000))
                  || (r > {1'b0, fdi_pkg::QLIM});

    always_comb begin
        state_next = state_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        neg_next   = neg_reg;
        p00_next   = p00_reg;
        mid_next   = mid_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        sat_next   = sat_reg;
        case (state_reg)
            Q_IDLE: begin
                if (start) begin
                    ma_next    = abs_a[fdi_pkg::QW-2:0];
                    mb_next    = abs_b[fdi_pkg::QW-2:0];
                    neg_next   = op_a[fdi_pkg::QW-1] != op_b[fdi_pkg::QW-1];
                    state_next = Q_M0;
                end
            end
            Q_M0: begin
                p00_next   = prod;
                state_next = Q_M1;
            end
            Q_M1: begin
                mid_next   = prod[fdi_pkg::QW-1:0];
                state_next = Q_M2;
            end
            Q_M2: begin
                mid_next   = mid_reg + prod[fdi_pkg::QW-1:0];
                state_next = Q_FIN;
            end
            Q_FIN: begin
                if (over) begin
                    res_next = neg_reg ? -fdi_pkg::QLIM : fdi_pkg::QLIM;
                end else begin
                    res_next = neg_reg ? -$signed(r[fdi_pkg::QW-1:0])
                                       : $signed(r[fdi_pkg::QW-1:0]);
                end
                sat_next   = over;
                done_next  = 1'b1;
                state_next = Q_IDLE;
            end
            default: begin
                state_next = Q_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= Q_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
        p00_reg <= p00_next;
        mid_reg <= mid_next;
        res_reg <= res_next;
        sat_reg <= sat_next;
    end

    assign done   = done_reg;
    assign result = res_reg;
    assign sat    = sat_reg;

endmodule

[src/forward_difference_interpolator_core.sv]
// Top level of the Newton forward difference interpolator: sample stores and sequencer.
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid/s_tready    s_tuser action, s_tdata sample and query
//  m_       out        m_tvalid/m_tready    m_tdata estimate, m_tuser error flag
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Load, clear and unused actions finish without leaving the idle state. An evaluation
// over n points uses the 49-step divider to form u and each coefficient quotient.
// Reset clears the load count, the sequencer and the output valid; the stores hold no reset.
// A finished estimate waits in the output register; loads are still taken meanwhile.
module forward_difference_interpolator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // sample_value [31:0], query_point [63:32]
    input  logic [1:0]  s_tuser,   // action [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // estimate [31:0]
    output logic [0:0]  m_tuser,   // error_flag [0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int QW    = fdi_pkg::QW;
    localparam int CNT_W = fdi_pkg::CNT_W;
    localparam int IDX_W = fdi_pkg::IDX_W;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_CPRD  = 5'd1;
    localparam logic [4:0] ST_CPWR  = 5'd2;
    localparam logic [4:0] ST_USTA  = 5'd3;
    localparam logic [4:0] ST_UWAIT = 5'd4;
    localparam logic [4:0] ST_DRD0  = 5'd5;
    localparam logic [4:0] ST_DLD0  = 5'd6;
    localparam logic [4:0] ST_DRD   = 5'd7;
    localparam logic [4:0] ST_DWR   = 5'd8;
    localparam logic [4:0] ST_COEF  = 5'd9;
    localparam logic [4:0] ST_CWAIT = 5'd10;
    localparam logic [4:0] ST_CDST  = 5'd11;
    localparam logic [4:0] ST_CDIV  = 5'd12;
    localparam logic [4:0] ST_TERM  = 5'd13;
    localparam logic [4:0] ST_TWAIT = 5'd14;
    localparam logic [4:0] ST_ACC   = 5'd15;
    localparam logic [4:0] ST_FINAL = 5'd16;
    localparam logic [4:0] ST_DONE  = 5'd17;

    logic [4:0]              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [31:0]      xorg_reg;
    logic [30:0]             step_reg;
    logic [4:0]              pc_reg;
    logic [CNT_W-1:0]        n_reg, n_next, i_reg, i_next, j_reg, j_next;
    logic signed [31:0]      query_reg, query_next;
    logic signed [QW-1:0]    acc_reg, acc_next, u_reg, u_next, c_reg, c_next;
    logic signed [QW-1:0]    term_reg, term_next;
    logic signed [31:0]      d_reg, d_next, prev_reg, prev_next;
    logic                    flag_reg, flag_next, csat_reg, csat_next;
    logic signed [31:0]      res_reg, res_next;
    logic                    rflag_reg, rflag_next;
    logic                    mval_reg, mval_next;
    logic [31:0]             mdata_reg, mdata_next;
    logic                    mflag_reg, mflag_next;

    logic [31:0]             sample_mem [fdi_pkg::MAX_POINTS];
    logic [31:0]             scratch_mem [fdi_pkg::MAX_POINTS];
    logic [31:0]             sample_rd_reg, scratch_rd_reg;
    logic                    sample_we, scratch_we;
    logic [IDX_W-1:0]        scr_raddr;
    logic [31:0]             scratch_wdata;

    logic                    s_acc;
    logic [CNT_W-1:0]        eff_n;
    logic signed [32:0]      xdiff;
    logic [32:0]             xmag;
    logic signed [32:0]      dsub;
    logic signed [31:0]      dval;
    logic                    dovf;
    logic signed [QW:0]      fwide, sum;
    logic signed [QW-1:0]    c_abs;
    logic signed [QW-1:0]    d_ext;

    logic                    div_start, div_done;
    logic [fdi_pkg::DVD_W-1:0] div_dvd, div_q;
    logic [fdi_pkg::DSR_W-1:0] div_dsr;
    logic                    mul_start, mul_done, mul_sat;
    logic signed [QW-1:0]    mul_a, mul_b, mul_res;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        if (pc_reg == '0) begin
            eff_n = CNT_W'(1);
        end else if (32'(pc_reg) > 32'(fdi_pkg::MAX_POINTS)) begin
            eff_n = CNT_W'(fdi_pkg::MAX_POINTS);
        end else begin
            eff_n = CNT_W'(pc_reg);
        end
    end

    assign xdiff = {query_reg[31], query_reg} - {xorg_reg[31], xorg_reg};
    assign xmag  = xdiff[32] ? 33'(-xdiff) : 33'(xdiff);
    assign c_abs = c_reg[QW-1] ? -c_reg : c_reg;
    assign d_ext = QW'(d_reg);

    // A difference saturates symmetrically to +-(2^31 - 1).
    assign dsub = {scratch_rd_reg[31], scratch_rd_reg} - {prev_reg[31], prev_reg};
    always_comb begin
        dovf = 1'b0;
        if (dsub > 33'sh0_7FFF_FFFF) begin
            dval = 32'sh7FFF_FFFF;
            dovf = 1'b1;
        end else if (dsub < -33'sh0_7FFF_FFFF) begin
            dval = -32'sh7FFF_FFFF;
            dovf = 1'b1;
        end else begin
            dval = dsub[31:0];
        end
    end

    assign fwide = {u_reg[QW-1], u_reg} - $signed({1'b0, QW'(j_reg - 1'b1) << 16});
    assign sum   = {acc_reg[QW-1], acc_reg} + {term_reg[QW-1], term_reg};

    assign div_start = (state_reg == ST_USTA) || (state_reg == ST_CDST);
    assign div_dvd   = (state_reg == ST_USTA) ? {xmag, 16'b0}
                                              : fdi_pkg::DVD_W'(c_abs[QW-2:0]);
    assign div_dsr   = (state_reg == ST_USTA) ? ((step_reg == '0) ? 31'd1 : step_reg)
                                              : fdi_pkg::DSR_W'(j_reg);

    assign mul_start = (state_reg == ST_COEF) ||
                       ((state_reg == ST_TERM) && (d_reg != 0) && (c_reg != 0) && !csat_reg);
    assign mul_a     = c_reg;
    assign mul_b     = (state_reg == ST_COEF) ? fdi_pkg::clamp_q(fwide) : d_ext;

    assign scr_raddr = (state_reg == ST_DRD) ? IDX_W'(i_reg + 1'b1) : '0;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        query_next = query_reg;
        acc_next   = acc_reg;
        u_next     = u_reg;
        c_next     = c_reg;
        term_next  = term_reg;
        d_next     = d_reg;
        prev_next  = prev_reg;
        flag_next  = flag_reg;
        csat_next  = csat_reg;
        res_next   = res_reg;
        rflag_next = rflag_reg;
        mval_next  = mval_reg;
        mdata_next = mdata_reg;
        mflag_next = mflag_reg;
        sample_we  = 1'b0;
        scratch_we = 1'b0;
        scratch_wdata = sample_rd_reg;
        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    case (s_tuser)
                        fdi_pkg::ACT_LOAD: begin
                            if (cnt_reg < CNT_W'(fdi_pkg::MAX_POINTS)) begin
                                sample_we = 1'b1;
                                cnt_next  = cnt_reg + 1'b1;
                            end
                        end
                        fdi_pkg::ACT_CLEAR: begin
                            cnt_next = '0;
                        end
                        fdi_pkg::ACT_EVAL: begin
                            n_next     = eff_n;
                            query_next = s_tdata[63:32];
                            flag_next  = 1'b0;
                            csat_next  = 1'b0;
                            c_next     = QW'(65536);
                            i_next     = '0;
                            if (cnt_reg < eff_n) begin
                                res_next   = '0;
                                rflag_next = 1'b1;
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_CPRD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CPRD: begin
                state_next = ST_CPWR;
            end
            ST_CPWR: begin
                scratch_we = 1'b1;
                if (i_reg == '0) begin
                    acc_next = QW'($signed(sample_rd_reg));
                end
                i_next = i_reg + 1'b1;
                if (i_reg + 1'b1 == n_reg) begin
                    j_next     = CNT_W'(1);
                    state_next = (n_reg == CNT_W'(1)) ? ST_FINAL : ST_USTA;
                end else begin
                    state_next = ST_CPRD;
                end
            end
            ST_USTA: begin
                state_next = ST_UWAIT;
            end
            ST_UWAIT: begin
                if (div_done) begin
                    if (div_q > fdi_pkg::DVD_W'(fdi_pkg::QLIM)) begin
                        u_next    = xdiff[32] ? -fdi_pkg::QLIM : fdi_pkg::QLIM;
                        flag_next = 1'b1;
                    end else begin
                        u_next = xdiff[32] ? -$signed(div_q[QW-1:0]) : $signed(div_q[QW-1:0]);
                    end
                    state_next = ST_DRD0;
                end
            end
            ST_DRD0: begin
                state_next = ST_DLD0;
            end
            ST_DLD0: begin
                prev_next  = scratch_rd_reg;
                i_next     = '0;
                state_next = ST_DRD;
            end
            ST_DRD: begin
                state_next = ST_DWR;
            end
            ST_DWR: begin
                scratch_we    = 1'b1;
                scratch_wdata = dval;
                if (dovf) begin
                    flag_next = 1'b1;
                end
                if (i_reg == '0) begin
                    d_next = dval;
                end
                prev_next = scratch_rd_reg;
                i_next    = i_reg + 1'b1;
                state_next = (i_reg + 1'b1 + j_reg == n_reg) ? ST_COEF : ST_DRD;
            end
            ST_COEF: begin
                state_next = ST_CWAIT;
            end
            ST_CWAIT: begin
                if (mul_done) begin
                    if (mul_sat || csat_reg) begin
                        csat_next = 1'b1;
                        if (mul_res != 0) begin
                            c_next = mul_res[QW-1] ? -fdi_pkg::QLIM : fdi_pkg::QLIM;
                        end else begin
                            c_next = '0;
                        end
                        state_next = ST_TERM;
                    end else begin
                        c_next     = mul_res;
                        state_next = ST_CDST;
                    end
                end
            end
            ST_CDST: begin
                state_next = ST_CDIV;
            end
            ST_CDIV: begin
                if (div_done) begin
                    c_next = c_reg[QW-1] ? -$signed(div_q[QW-1:0]) : $signed(div_q[QW-1:0]);
                    state_next = ST_TERM;
                end
            end
            ST_TERM: begin
                if ((d_reg == 0) || (c_reg == 0)) begin
                    term_next  = '0;
                    state_next = ST_ACC;
                end else if (csat_reg) begin
                    term_next  = (c_reg[QW-1] != d_reg[31]) ? -fdi_pkg::QLIM : fdi_pkg::QLIM;
                    flag_next  = 1'b1;
                    state_next = ST_ACC;
                end else begin
                    state_next = ST_TWAIT;
                end
            end
            ST_TWAIT: begin
                if (mul_done) begin
                    term_next = mul_res;
                    if (mul_sat) begin
                        flag_next = 1'b1;
                    end
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                acc_next = fdi_pkg::clamp_q(sum);
                if (fdi_pkg::ovf_q(sum)) begin
                    flag_next = 1'b1;
                end
                j_next = j_reg + 1'b1;
                state_next = (j_reg + 1'b1 == n_reg) ? ST_FINAL : ST_DRD0;
            end
            ST_FINAL: begin
                rflag_next = flag_reg;
                if (acc_reg > QW'(32'sh7FFF_FFFF)) begin
                    res_next   = 32'sh7FFF_FFFF;
                    rflag_next = 1'b1;
                end else if (acc_reg < -(QW'(64'sh8000_0000))) begin
                    res_next   = 32'sh8000_0000;
                    rflag_next = 1'b1;
                end else begin
                    res_next = acc_reg[31:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!mval_reg || m_tready) begin
                    mval_next  = 1'b1;
                    mdata_next = res_reg;
                    mflag_next = rflag_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            mval_reg  <= 1'b0;
            xorg_reg  <= '0;
            step_reg  <= 31'd65536;
            pc_reg    <= 5'd16;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mval_reg  <= mval_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    fdi_pkg::REG_X_ORIGIN:    xorg_reg <= cfg_data;
                    fdi_pkg::REG_STEP_SIZE:   step_reg <= cfg_data[30:0];
                    fdi_pkg::REG_POINT_COUNT: pc_reg   <= cfg_data[4:0];
                    default: begin
                    end
                endcase
            end
        end
        n_reg     <= n_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        query_reg <= query_next;
        acc_reg   <= acc_next;
        u_reg     <= u_next;
        c_reg     <= c_next;
        term_reg  <= term_next;
        d_reg     <= d_next;
        prev_reg  <= prev_next;
        flag_reg  <= flag_next;
        csat_reg  <= csat_next;
        res_reg   <= res_next;
        rflag_reg <= rflag_next;
        mdata_reg <= mdata_next;
        mflag_reg <= mflag_next;
    end

    always_ff @(posedge aclk) begin
        if (sample_we) begin
            sample_mem[cnt_reg[IDX_W-1:0]] <= s_tdata[31:0];
        end
        sample_rd_reg <= sample_mem[i_reg[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (scratch_we) begin
            scratch_mem[i_reg[IDX_W-1:0]] <= scratch_wdata;
        end
        scratch_rd_reg <= scratch_mem[scr_raddr];
    end

    fdi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    fdi_qmul u_qmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .result  (mul_res),
        .sat     (mul_sat)
    );

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = mflag_reg;

endmodule

[src/fdi_checker.sv]
// Port-level checks for the interpolator core, bound to the top level.
module fdi_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index,
    input logic [31:0] cfg_data
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An evaluation transfer keeps the input closed in the next cycle.
    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == fdi_pkg::ACT_EVAL) |=> !s_tready)
        else $error("input open right after an evaluation");

    // Loads and clears finish at once and leave the input open.
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready &&
        ((s_tuser == fdi_pkg::ACT_LOAD) || (s_tuser == fdi_pkg::ACT_CLEAR)) |=> s_tready)
        else $error("input closed after a load or clear");

endmodule

bind forward_difference_interpolator_core fdi_checker u_fdi_checker (.*);
